// File: hw/rtl/tlj_pkg.sv
// ----------------------------------------------------------------------------
// tlj_pkg
// Shared widths, character codes and control structs for the text line
// justifier and its line store and divider.
// ----------------------------------------------------------------------------
package tlj_pkg;

   localparam int CHAR_W      = 8;
   localparam int MAX_WIDTH   = 64;
   localparam int CNT_W       = $clog2(MAX_WIDTH + 1);
   // ring buffer: twice the line size so a line plus one byte never wraps onto itself
   localparam int ADDR_W      = CNT_W;
   localparam int STORE_DEPTH = 1 << ADDR_W;

   typedef logic [CHAR_W-1:0] char_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [ADDR_W-1:0] addr_type;

   localparam char_type SPACE_CH   = 8'h20;
   localparam char_type NEWLINE_CH = 8'h0A;
   localparam cnt_type  NO_SPACE   = '1;
   localparam cnt_type  WIDTH_MAX  = CNT_W'(MAX_WIDTH);
   localparam cnt_type  WIDTH_MIN  = CNT_W'(1);

   // line store write and read requests
   typedef struct packed {
      logic     en;
      addr_type addr;
      char_type data;
   } store_wr_type;

   typedef struct packed {
      logic     en;
      addr_type addr;
   } store_rd_type;

   // divider command and result
   typedef struct packed {
      logic    start;
      cnt_type dividend;
      cnt_type divisor;
   } div_cmd_type;

   typedef struct packed {
      logic    done;
      cnt_type quotient;
      cnt_type remainder;
   } div_res_type;

endpackage

// File: hw/rtl/tlj_if.sv
// ----------------------------------------------------------------------------
// tlj_if
// Valid/ready channel interfaces: input words, output words and the width
// register write port.
// ----------------------------------------------------------------------------
interface tlj_req_if
   import tlj_pkg::*;
();
   logic     valid;
   logic     ready;
   char_type in_char;

   modport source (output valid, output in_char, input ready);
   modport sink   (input valid, input in_char, output ready);
endinterface

interface tlj_rsp_if
   import tlj_pkg::*;
();
   logic     valid;
   logic     ready;
   char_type out_char;
   logic     line_end;
   logic     overlong_word;

   modport source (output valid, output out_char, output line_end, output overlong_word,
                   input ready);
   modport sink   (input valid, input out_char, input line_end, input overlong_word,
                   output ready);
endinterface

interface tlj_csr_if
   import tlj_pkg::*;
();
   logic    valid;
   logic    ready;
   cnt_type line_width;

   modport source (output valid, output line_width, input ready);
   modport sink   (input valid, input line_width, output ready);
endinterface

// File: hw/rtl/tlj_line_store.sv
// ----------------------------------------------------------------------------
// tlj_line_store
// Ring buffer memory for the current line: one write port, one read port
// with registered read data.
// ----------------------------------------------------------------------------
module tlj_line_store
   import tlj_pkg::*;
(
   input  logic         clock,
   input  store_wr_type wr,
   input  store_rd_type rd,
   output char_type     rd_data
);

   char_type mem [STORE_DEPTH];
   char_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // read port, data holds until the next read
   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/tlj_divider.sv
// ----------------------------------------------------------------------------
// tlj_divider
// Repeated-subtraction divider for the padding split: quotient and
// remainder of the free columns over the space count. A zero divisor
// gives zero for both.
// ----------------------------------------------------------------------------
module tlj_divider
   import tlj_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_cmd_type cmd,
   output div_res_type res
);

   logic    busy_ff, busy_in;
   cnt_type rem_ff, rem_in;
   cnt_type quo_ff, quo_in;
   cnt_type dvs_ff, dvs_in;
   logic    finish;

   // finished when nothing more can be taken off
   assign finish = busy_ff && ((dvs_ff == '0) || (rem_ff < dvs_ff));

   always_comb begin
      busy_in = busy_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         rem_in  = cmd.dividend;
         quo_in  = '0;
         dvs_in  = cmd.divisor;
      end else if (finish) begin
         busy_in = 1'b0;
      end else if (busy_ff) begin
         rem_in = rem_ff - dvs_ff;
         quo_in = quo_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign res.done      = finish;
   assign res.quotient  = quo_ff;
   assign res.remainder = (dvs_ff == '0) ? '0 : rem_ff;

endmodule

// File: hw/rtl/text_line_justifier.sv
// ----------------------------------------------------------------------------
// text_line_justifier
// Greedy word wrap with full justification, one input word at a time.
// ----------------------------------------------------------------------------
// Usage:
//  req_ch carries one text byte per word. A byte that fits on the line is
//  stored and the block is ready again the next cycle.
//  A byte that breaks the line (newline, or any byte on a full line) starts
//  a sequence during which req_ch.ready is low:
//    - space scan of the emitted segment, one store read per byte,
//    - padding split on the subtract-loop divider,
//    - emission of each stored byte and of the pad spaces of each gap after
//      a space and at the tail, while rsp_ch is ready,
//    - line done: the line start moves past the break and the new byte is
//      stored, unless a newline or a space on a full line emptied the line.
//  rsp_ch delivers exactly width words per line, line_end on the last one.
//  csr_ch writes the line width (clamped to 1..64) and is always ready; write
//  it only while the block is idle.
//  Reset empties the line and sets the width to 64. When rsp_ch stalls, the
//  output register holds its word and the sequencer waits.
// ----------------------------------------------------------------------------
module text_line_justifier
   import tlj_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   tlj_req_if.sink    req_ch,
   tlj_rsp_if.source  rsp_ch,
   tlj_csr_if.sink    csr_ch
);

   // sequencer states
   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_COUNT    = 3'd1;
   localparam logic [2:0] S_DIV_GO   = 3'd2;
   localparam logic [2:0] S_DIV_WAIT = 3'd3;
   localparam logic [2:0] S_RD       = 3'd4;
   localparam logic [2:0] S_CH       = 3'd5;
   localparam logic [2:0] S_PAD      = 3'd6;
   localparam logic [2:0] S_FIN      = 3'd7;

   logic [2:0] state_ff, state_in;
   cnt_type    width_ff, width_in;
   cnt_type    fill_ff, fill_in;
   cnt_type    sp_ff, sp_in;
   addr_type   base_ff, base_in;

   char_type   c_ff, c_in;
   cnt_type    len_ff, len_in;
   cnt_type    w_ff, w_in;
   cnt_type    shift_ff, shift_in;
   logic       flag_ff, flag_in;
   logic       carry_ff, carry_in;
   cnt_type    idx_ff, idx_in;
   logic       rdv_ff, rdv_in;
   cnt_type    spc_ff, spc_in;
   cnt_type    q_ff, q_in;
   cnt_type    r_ff, r_in;
   cnt_type    n_ff, n_in;
   cnt_type    pad_ff, pad_in;

   logic       out_valid_ff, out_valid_in;
   char_type   out_char_ff, out_char_in;
   logic       out_end_ff, out_end_in;
   logic       out_flag_ff, out_flag_in;

   store_wr_type st_wr;
   store_rd_type st_rd;
   char_type     st_data;
   div_cmd_type  div_cmd;
   div_res_type  div_res;

   cnt_type    eff_w;
   logic       accept;
   logic       slot_free;

   tlj_line_store u_store (
      .clock   (clock),
      .wr      (st_wr),
      .rd      (st_rd),
      .rd_data (st_data)
   );

   tlj_divider u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .res   (div_res)
   );

   // effective width, clamped
   always_comb begin
      if (width_ff == '0) begin
         eff_w = WIDTH_MIN;
      end else if (width_ff > WIDTH_MAX) begin
         eff_w = WIDTH_MAX;
      end else begin
         eff_w = width_ff;
      end
   end

   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;
   assign slot_free    = !out_valid_ff || rsp_ch.ready;

   // sequencer
   always_comb begin
      cnt_type seg_len;
      logic    seg_flag;
      logic    is_sp;

      state_in     = state_ff;
      width_in     = width_ff;
      fill_in      = fill_ff;
      sp_in        = sp_ff;
      base_in      = base_ff;
      c_in         = c_ff;
      len_in       = len_ff;
      w_in         = w_ff;
      shift_in     = shift_ff;
      flag_in      = flag_ff;
      carry_in     = carry_ff;
      idx_in       = idx_ff;
      rdv_in       = rdv_ff;
      spc_in       = spc_ff;
      q_in         = q_ff;
      r_in         = r_ff;
      n_in         = n_ff;
      pad_in       = pad_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      out_char_in  = out_char_ff;
      out_end_in   = out_end_ff;
      out_flag_in  = out_flag_ff;
      st_wr        = '0;
      st_rd        = '0;
      div_cmd      = '0;
      seg_len      = '0;
      seg_flag     = 1'b0;
      is_sp        = 1'b0;

      if (csr_ch.valid) begin
         width_in = csr_ch.line_width;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               is_sp    = (req_ch.in_char == SPACE_CH);
               c_in     = req_ch.in_char;
               w_in     = eff_w;
               idx_in   = '0;
               rdv_in   = 1'b0;
               spc_in   = '0;
               shift_in = '0;
               carry_in = 1'b0;
               if (req_ch.in_char == NEWLINE_CH || (fill_ff >= eff_w && is_sp)) begin
                  // whole line out, then empty
                  seg_len  = fill_ff;
                  state_in = S_COUNT;
               end else if (fill_ff < eff_w) begin
                  // append to the line
                  st_wr.en   = 1'b1;
                  st_wr.addr = base_ff + ADDR_W'(fill_ff);
                  st_wr.data = req_ch.in_char;
                  fill_in    = fill_ff + CNT_W'(1);
                  if (is_sp) begin
                     sp_in = fill_ff;
                  end
               end else if (sp_ff < fill_ff) begin
                  // break at the last space
                  seg_len  = sp_ff;
                  shift_in = sp_ff + CNT_W'(1);
                  carry_in = 1'b1;
                  state_in = S_COUNT;
               end else begin
                  // word longer than the line: cut it
                  seg_len  = eff_w;
                  seg_flag = 1'b1;
                  shift_in = eff_w;
                  carry_in = 1'b1;
                  state_in = S_COUNT;
               end
               if (seg_len > eff_w) begin
                  seg_len  = eff_w;
                  seg_flag = 1'b1;
               end
               len_in  = seg_len;
               flag_in = seg_flag;
            end
         end

         // count spaces in the segment, one store read per cycle
         S_COUNT: begin
            if (idx_ff < len_ff) begin
               st_rd.en   = 1'b1;
               st_rd.addr = base_ff + ADDR_W'(idx_ff);
               idx_in     = idx_ff + CNT_W'(1);
               rdv_in     = 1'b1;
            end else begin
               rdv_in = 1'b0;
            end
            if (rdv_ff && st_data == SPACE_CH) begin
               spc_in = spc_ff + CNT_W'(1);
            end
            if (idx_ff >= len_ff && !rdv_ff) begin
               state_in = S_DIV_GO;
            end
         end

         // split the free columns over the spaces
         S_DIV_GO: begin
            div_cmd.start    = 1'b1;
            div_cmd.dividend = w_ff - len_ff;
            div_cmd.divisor  = spc_ff;
            state_in         = S_DIV_WAIT;
         end

         S_DIV_WAIT: begin
            if (div_res.done) begin
               q_in     = div_res.quotient;
               r_in     = div_res.remainder;
               idx_in   = '0;
               n_in     = '0;
               state_in = S_RD;
            end
         end

         // fetch the next stored byte, pad the tail, or finish the line
         S_RD: begin
            if (idx_ff < len_ff && n_ff < w_ff) begin
               st_rd.en   = 1'b1;
               st_rd.addr = base_ff + ADDR_W'(idx_ff);
               idx_in     = idx_ff + CNT_W'(1);
               state_in   = S_CH;
            end else if (n_ff < w_ff) begin
               pad_in   = w_ff - n_ff;
               state_in = S_PAD;
            end else begin
               state_in = S_FIN;
            end
         end

         // send a stored byte; a space opens a gap
         S_CH: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_char_in  = st_data;
               out_end_in   = (n_ff + CNT_W'(1) == w_ff);
               out_flag_in  = flag_ff;
               n_in         = n_ff + CNT_W'(1);
               if (spc_ff != '0 && st_data == SPACE_CH) begin
                  pad_in = q_ff + CNT_W'(r_ff != '0);
                  if (r_ff != '0) begin
                     r_in = r_ff - CNT_W'(1);
                  end
                  state_in = S_PAD;
               end else begin
                  state_in = S_RD;
               end
            end
         end

         // send pad spaces
         S_PAD: begin
            if (pad_ff == '0 || n_ff == w_ff) begin
               state_in = S_RD;
            end else if (slot_free) begin
               out_valid_in = 1'b1;
               out_char_in  = SPACE_CH;
               out_end_in   = (n_ff + CNT_W'(1) == w_ff);
               out_flag_in  = flag_ff;
               n_in         = n_ff + CNT_W'(1);
               pad_in       = pad_ff - CNT_W'(1);
            end
         end

         // drop the emitted part; on a carry keep the rest and store the new byte, else empty the line
         S_FIN: begin
            if (carry_ff) begin
               st_wr.en   = 1'b1;
               st_wr.addr = base_ff + ADDR_W'(fill_ff);
               st_wr.data = c_ff;
               base_in    = base_ff + ADDR_W'(shift_ff);
               fill_in    = fill_ff - shift_ff + CNT_W'(1);
            end else begin
               fill_in = '0;
            end
            sp_in    = NO_SPACE;
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         width_ff     <= WIDTH_MAX;
         fill_ff      <= '0;
         sp_ff        <= NO_SPACE;
         base_ff      <= '0;
         rdv_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         width_ff     <= width_in;
         fill_ff      <= fill_in;
         sp_ff        <= sp_in;
         base_ff      <= base_in;
         rdv_ff       <= rdv_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // working registers and output word
   always_ff @(posedge clock) begin
      c_ff        <= c_in;
      len_ff      <= len_in;
      w_ff        <= w_in;
      shift_ff    <= shift_in;
      flag_ff     <= flag_in;
      carry_ff    <= carry_in;
      idx_ff      <= idx_in;
      spc_ff      <= spc_in;
      q_ff        <= q_in;
      r_ff        <= r_in;
      n_ff        <= n_in;
      pad_ff      <= pad_in;
      out_char_ff <= out_char_in;
      out_end_ff  <= out_end_in;
      out_flag_ff <= out_flag_in;
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.out_char      = out_char_ff;
   assign rsp_ch.line_end      = out_end_ff;
   assign rsp_ch.overlong_word = out_flag_ff;

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for text_line_justifier. Text bytes go in over req_ch
// and a line model predicts every justified output word. Each word taken
// from rsp_ch is compared field by field against the oldest predicted word.
// The line width is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench
   import tlj_pkg::*;
();

   localparam int RESET_CYCLES  = 7;
   localparam int STALL_LIMIT   = 5000;
   localparam int SETTLE_CYCLES = 8;
   localparam int END_CYCLES    = 20;
   localparam int LONG_HOLD     = 300;
   localparam int PHASE_ITEMS   = 44;
   localparam int NUM_PHASES    = 8;

   typedef enum int {IDLE_SEND_LIGHT, IDLE_SEND_HEAVY, IDLE_NONE} idle_mode_type;

   // --------------------------------------------------------------------------
   // Line model and expected word store
   // --------------------------------------------------------------------------
   class justify_scoreboard;
      typedef struct packed {
         char_type ch;
         logic     last;
         logic     cut;
      } line_word_type;

      char_type      line_buf[MAX_WIDTH+1];
      int unsigned   fill;
      int unsigned   space_at;
      cnt_type       width_reg;
      line_word_type expected[$];
      int            errors;

      function new();
         fill      = 0;
         space_at  = NO_SPACE;
         width_reg = WIDTH_MAX;
         errors    = 0;
      endfunction

      function void set_width(cnt_type value);
         width_reg = value;
      endfunction

      function int pending();
         return expected.size();
      endfunction

      function int unsigned eff_width();
         int unsigned w;
         w = width_reg;
         if (w < WIDTH_MIN) w = WIDTH_MIN;
         if (w > WIDTH_MAX) w = WIDTH_MAX;
         return w;
      endfunction

      function void push_word(char_type ch, bit last, bit cut);
         line_word_type wd;
         wd.ch   = ch;
         wd.last = last;
         wd.cut  = cut;
         expected.push_back(wd);
      endfunction

      // spread the padding over the spaces of line_buf[0..len-1], left gaps first
      function void justify(int unsigned len, int unsigned w, bit cut);
         int unsigned spaces, extra, q, r, pad, n;
         spaces = 0;
         n      = 0;
         if (len > w) begin
            len = w;
            cut = 1'b1;
         end
         for (int i = 0; i < len; i++)
            if (line_buf[i] == SPACE_CH) spaces++;
         extra = w - len;
         q     = spaces ? extra / spaces : 0;
         r     = spaces ? extra % spaces : 0;
         for (int i = 0; i < len && n < w; i++) begin
            push_word(line_buf[i], n + 1 == w, cut);
            n++;
            if (spaces != 0 && line_buf[i] == SPACE_CH) begin
               pad = q + ((r > 0) ? 1 : 0);
               if (r > 0) r--;
               for (int g = 0; g < pad && n < w; g++) begin
                  push_word(SPACE_CH, n + 1 == w, cut);
                  n++;
               end
            end
         end
         while (n < w) begin
            push_word(SPACE_CH, n + 1 == w, cut);
            n++;
         end
      endfunction

      // accepted input byte: update the line and predict any emitted words
      function void note_char(char_type c);
         int unsigned w, f, sp, carry;
         w  = eff_width();
         f  = (fill > MAX_WIDTH) ? MAX_WIDTH : fill;
         sp = space_at;
         if (c == NEWLINE_CH) begin
            justify(f, w, 1'b0);
            fill     = 0;
            space_at = NO_SPACE;
            return;
         end
         if (f < w) begin
            line_buf[f] = c;
            if (c == SPACE_CH) space_at = f;
            fill = f + 1;
            return;
         end
         if (c == SPACE_CH) begin
            justify(f, w, 1'b0);
            fill     = 0;
            space_at = NO_SPACE;
            return;
         end
         // full line: break at the last space, else cut the word
         if (sp < f) begin
            justify(sp, w, 1'b0);
            carry = f - sp - 1;
            for (int k = 0; k < carry; k++) line_buf[k] = line_buf[sp + 1 + k];
         end else begin
            justify(w, w, 1'b1);
            carry = f - w;
            for (int k = 0; k < carry; k++) line_buf[k] = line_buf[w + k];
         end
         line_buf[carry] = c;
         fill            = carry + 1;
         space_at        = NO_SPACE;
      endfunction

      function void check_word(char_type ch, logic last, logic cut);
         line_word_type wd;
         if (expected.size() == 0) begin
            $display("%0t: unexpected output word, char %02h line_end %b overlong %b",
                     $time, ch, last, cut);
            errors++;
            return;
         end
         wd = expected.pop_front();
         if (ch !== wd.ch) begin
            $display("%0t: out_char expected %02h actual %02h", $time, wd.ch, ch);
            errors++;
         end
         if (last !== wd.last) begin
            $display("%0t: line_end expected %b actual %b", $time, wd.last, last);
            errors++;
         end
         if (cut !== wd.cut) begin
            $display("%0t: overlong_word expected %b actual %b", $time, wd.cut, cut);
            errors++;
         end
      endfunction
   endclass

   // --------------------------------------------------------------------------
   // Clock, channels and the block
   // --------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   tlj_req_if req_ch ();
   tlj_rsp_if rsp_ch ();
   tlj_csr_if csr_ch ();

   text_line_justifier u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   justify_scoreboard sb = new();

   int send_idle_pct = 0;
   int rsp_idle_pct  = 0;
   bit long_hold_req = 1'b0;

   initial begin
      req_ch.valid      = 1'b0;
      req_ch.in_char    = '0;
      rsp_ch.ready      = 1'b0;
      csr_ch.valid      = 1'b0;
      csr_ch.line_width = '0;
   end

   // --------------------------------------------------------------------------
   // Output side: check accepted words, then pick the next ready
   // --------------------------------------------------------------------------
   initial begin : rsp_side
      int  hold_left;
      bit  hold_taken;
      hold_left  = 0;
      hold_taken = 1'b0;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            sb.check_word(rsp_ch.out_char, rsp_ch.line_end, rsp_ch.overlong_word);
         // one long hold-off so the block backs up into its input
         if (long_hold_req && !hold_taken) begin
            hold_left  = LONG_HOLD;
            hold_taken = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // --------------------------------------------------------------------------
   // Watchdog on cycles with no handshake at all
   // --------------------------------------------------------------------------
   int stall_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) ||
          (csr_ch.valid === 1'b1 && csr_ch.ready === 1'b1)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles == STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("Verification failed");
            $finish;
         end
      end
   end

   // --------------------------------------------------------------------------
   // Input side tasks
   // --------------------------------------------------------------------------
   task automatic send_char(input char_type c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.in_char <= c;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      sb.note_char(c);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(char_type'(s[i]));
   endtask

   // stop sending and let every predicted word drain
   task automatic settle(input int extra_cycles);
      req_ch.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (extra_cycles) @(posedge clock);
   endtask

   task automatic write_width(input cnt_type value);
      csr_ch.valid      <= 1'b1;
      csr_ch.line_width <= value;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      csr_ch.valid <= 1'b0;
      sb.set_width(value);
   endtask

   // mostly short words and single spaces, some newlines, some raw bytes
   function automatic char_type random_text_char();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 6)  return NEWLINE_CH;
      if (roll < 22) return SPACE_CH;
      if (roll < 30) return char_type'($urandom_range(255));
      return char_type'(8'h61 + $urandom_range(25));
   endfunction

   function automatic void set_idle(idle_mode_type mode);
      case (mode)
         IDLE_SEND_LIGHT: begin
            send_idle_pct = 32;
            rsp_idle_pct  = 71;
         end
         IDLE_SEND_HEAVY: begin
            send_idle_pct = 71;
            rsp_idle_pct  = 32;
         end
         default: begin
            send_idle_pct = 0;
            rsp_idle_pct  = 0;
         end
      endcase
   endfunction

   // --------------------------------------------------------------------------
   // Main sequence
   // --------------------------------------------------------------------------
   cnt_type phase_width[NUM_PHASES] = '{7'd0, 7'd64, 7'd5, 7'd127, 7'd13, 7'd2, 7'd37, 7'd9};

   initial begin : main_seq
      idle_mode_type mode;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty line at reset width, then width 8 cases
      set_idle(IDLE_SEND_LIGHT);
      send_char(NEWLINE_CH);
      settle(SETTLE_CYCLES);
      write_width(7'd8);
      send_text("a b c de");        // fills the line
      send_text("f");               // breaks at last space, uneven gaps
      send_text("ghijk");           // full line without space
      send_char(SPACE_CH);          // space on a full line
      send_text("lmnopq");
      send_char(8'hFF);
      send_char(8'h00);
      send_text("t");               // overlong word is cut
      send_char(NEWLINE_CH);        // no space: padding at the end

      // random phases; the line may still hold text when the width changes
      for (int p = 0; p < NUM_PHASES; p++) begin
         settle(SETTLE_CYCLES);
         mode = (p < 3) ? IDLE_SEND_LIGHT : (p < 6) ? IDLE_SEND_HEAVY : IDLE_NONE;
         set_idle(mode);
         write_width(phase_width[p]);
         if (p == 6) long_hold_req = 1'b1;
         for (int i = 0; i < PHASE_ITEMS; i++) send_char(random_text_char());
      end

      settle(END_CYCLES);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// File: text_line_justifier.f
hw/rtl/tlj_pkg.sv
hw/rtl/tlj_if.sv
hw/rtl/tlj_line_store.sv
hw/rtl/tlj_divider.sv
hw/rtl/text_line_justifier.sv
tb/sv/testbench.sv
